/* rtl/iirlp5_pkg.sv */
package iirlp5_pkg;

    localparam int FILTER_ORDER = 5;
    localparam int COEF_W       = 24;
    localparam int COEF_FRAC    = 20;
    localparam int HIST_SHIFT   = 8;
    localparam int HIST_EXTRA   = 8;

    typedef logic signed [COEF_W-1:0] t_coef;

    // index 0 is the oldest history entry
    localparam t_coef FB_COEF [FILTER_ORDER] = '{
        24'sd131491, -24'sd923900, 24'sd2668940, -24'sd3990880, 24'sd3118989
    };
    localparam t_coef FF_COEF [FILTER_ORDER] = '{
        24'sd1363, 24'sd6711, 24'sd13422, 24'sd13422, 24'sd6711
    };
    localparam t_coef FF_NOW = 24'sd1363;

endpackage

/* rtl/iirlp5_core.sv */
module iirlp5_core #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_advance,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample,
    output logic signed [SAMPLE_WIDTH-1:0] o_filtered
);
    import iirlp5_pkg::*;

    localparam int HW    = SAMPLE_WIDTH + HIST_EXTRA;
    localparam int ACC_W = HW + COEF_W + 2;
    localparam int FBP_W = HW + COEF_W;
    localparam int FFP_W = SAMPLE_WIDTH + COEF_W;

    localparam logic signed [ACC_W-1:0] ACC_HALF = ACC_W'(1) <<< (COEF_FRAC - 1);
    localparam logic signed [ACC_W-1:0] H_MAX    = (ACC_W'(1) <<< (HW - 1)) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] H_MIN    = -H_MAX - ACC_W'(1);
    localparam logic signed [HW:0]      OUT_HALF = (HW + 1)'(1) <<< (HIST_SHIFT - 1);
    localparam logic signed [HW:0]      S_MAX    =
        ((HW + 1)'(1) <<< (SAMPLE_WIDTH - 1)) - (HW + 1)'(1);
    localparam logic signed [HW:0]      S_MIN    = -S_MAX - (HW + 1)'(1);

    logic signed [SAMPLE_WIDTH-1:0] r_xh [FILTER_ORDER];
    logic signed [HW-1:0]           r_yh [FILTER_ORDER];

    logic signed [ACC_W-1:0] w_fb_sum;
    logic signed [ACC_W-1:0] w_ff_sum;
    logic signed [ACC_W-1:0] w_acc;
    logic signed [ACC_W-1:0] w_y_wide;
    logic signed [HW-1:0]    w_y_hist;
    logic signed [HW:0]      w_y_rnd;
    logic signed [HW:0]      w_o_wide;

    always_comb begin
        logic signed [FBP_W-1:0] fb_prod;
        logic signed [FFP_W-1:0] ff_prod;
        w_fb_sum = '0;
        w_ff_sum = '0;
        for (int i = 0; i < FILTER_ORDER; i++) begin
            fb_prod  = FBP_W'(r_yh[i]) * FBP_W'(FB_COEF[i]);
            ff_prod  = FFP_W'(r_xh[i]) * FFP_W'(FF_COEF[i]);
            w_fb_sum = w_fb_sum + ACC_W'(fb_prod);
            w_ff_sum = w_ff_sum + ACC_W'(ff_prod);
        end
        ff_prod  = FFP_W'(i_sample) * FFP_W'(FF_NOW);
        w_ff_sum = w_ff_sum + ACC_W'(ff_prod);
        w_acc    = w_fb_sum + (w_ff_sum <<< HIST_SHIFT);
        w_y_wide = (w_acc + ACC_HALF) >>> COEF_FRAC;
        if (w_y_wide > H_MAX) begin
            w_y_hist = HW'(H_MAX);
        end else if (w_y_wide < H_MIN) begin
            w_y_hist = HW'(H_MIN);
        end else begin
            w_y_hist = HW'(w_y_wide);
        end
        w_y_rnd  = (HW + 1)'(w_y_hist) + OUT_HALF;
        w_o_wide = w_y_rnd >>> HIST_SHIFT;
        if (w_o_wide > S_MAX) begin
            o_filtered = SAMPLE_WIDTH'(S_MAX);
        end else if (w_o_wide < S_MIN) begin
            o_filtered = SAMPLE_WIDTH'(S_MIN);
        end else begin
            o_filtered = SAMPLE_WIDTH'(w_o_wide);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < FILTER_ORDER; i++) begin
                r_xh[i] <= '0;
                r_yh[i] <= '0;
            end
        end else if (i_advance) begin
            for (int i = 0; i < FILTER_ORDER - 1; i++) begin
                r_xh[i] <= r_xh[i+1];
                r_yh[i] <= r_yh[i+1];
            end
            r_xh[FILTER_ORDER-1] <= i_sample;
            r_yh[FILTER_ORDER-1] <= w_y_hist;
        end
    end

endmodule

/* rtl/iir_lowpass_order5_top.sv */
// An accepted input transaction is registered at the input, then its result at the output.
// Throughput: one transaction per cycle while the output is not stalled.
// The input register takes one more sample while a finished result waits to be taken.
// Reset: synchronous, active low; clears both valid flags and both filter histories.
module iir_lowpass_order5_top #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample_in,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic signed [SAMPLE_WIDTH-1:0] o_filtered_out
);
    import iirlp5_pkg::*;

    logic                           r_in_valid;
    logic                           n_in_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_in_sample;
    logic                           r_out_valid;
    logic                           n_out_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_out_data;
    logic                           w_advance;
    logic                           w_accept;
    logic signed [SAMPLE_WIDTH-1:0] w_filtered;

    assign w_advance = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !w_advance;
    assign w_accept = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_filtered_out = r_out_data;

    always_comb begin
        n_in_valid = r_in_valid;
        if (!o_in_stall) begin
            n_in_valid = i_in_valid;
        end
        n_out_valid = r_out_valid;
        if (w_advance) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    iirlp5_core #(
        .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_advance  (w_advance),
        .i_sample   (r_in_sample),
        .o_filtered (w_filtered)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_sample <= i_sample_in;
        end
        if (w_advance) begin
            r_out_data <= w_filtered;
        end
    end

`ifndef NO_ASSERTIONS
    a_advance_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |=> r_out_valid)
        else $error("advanced transaction did not reach the output register");

    a_stall_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid && i_out_stall))
        else $error("input stalled without a blocked transaction");

    a_accept_fills_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_in_valid)
        else $error("accepted transaction lost from the input register");

    a_held_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> (r_out_valid && $stable(r_out_data)))
        else $error("stalled result dropped or changed");
`endif

endmodule

/* tb/tb_iir_lowpass_order5_top.sv */
`timescale 1ns / 100ps

module tb_iir_lowpass_order5_top;

    localparam int SW          = 16;
    localparam int HW          = SW + 8;
    localparam int TAPS        = 5;
    localparam int CYCLE_LIMIT = 300000;
    localparam int LONG_HOLD   = 200;
    localparam int RAND_ITEMS  = 1350;

    localparam logic signed [SW-1:0] S_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] S_MIN = {1'b1, {(SW-1){1'b0}}};

    // Q4.20 taps, index 0 oldest
    localparam longint FB_TAP [TAPS] = '{131491, -923900, 2668940, -3990880, 3118989};
    localparam longint FF_TAP [TAPS] = '{1363, 6711, 13422, 13422, 6711};
    localparam longint FF_CUR = 1363;

    typedef struct {
        logic signed [SW-1:0] sample;
        int unsigned          gap;
        bit                   drain;
    } t_sample_item;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic signed [SW-1:0] i_sample_in = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic signed [SW-1:0] o_filtered_out;

    t_sample_item         pending_samples[$];
    logic signed [SW-1:0] filt_expect_q[$];
    logic signed [SW-1:0] x_hist [TAPS];
    logic signed [HW-1:0] y_hist [TAPS];

    int                   total_items = 0;
    int                   samples_sent = 0;
    int                   results_seen = 0;
    int                   err_count = 0;
    int                   hist_clamps = 0;
    int                   in_stall_cycles = 0;
    int                   cycle_count = 0;
    int unsigned          gap_count = 0;
    logic                 acc_strobe = 1'b0;
    logic signed [SW-1:0] acc_sample = '0;
    logic signed [SW-1:0] predicted;
    logic signed [SW-1:0] expected;
    int unsigned          rx_wait = 0;
    int unsigned          rx_burst_left = 0;
    int unsigned          hold_left = 0;
    int                   holds_done = 0;

    iir_lowpass_order5_top #(
        .SAMPLE_WIDTH(SW)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_sample_in   (i_sample_in),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_filtered_out(o_filtered_out)
    );

    always #6 i_clk = ~i_clk;

    function automatic logic signed [SW-1:0] advance_filter(input logic signed [SW-1:0] x);
        longint fb_sum;
        longint ff_sum;
        longint acc;
        longint y_full;
        longint o_full;
        longint y_hi;
        longint o_hi;
        y_hi   = (longint'(1) <<< (HW - 1)) - 1;
        o_hi   = (longint'(1) <<< (SW - 1)) - 1;
        fb_sum = 0;
        ff_sum = FF_CUR * longint'(x);
        for (int k = 0; k < TAPS; k++) begin
            fb_sum += FB_TAP[k] * longint'(y_hist[k]);
            ff_sum += FF_TAP[k] * longint'(x_hist[k]);
        end
        acc    = fb_sum + (ff_sum <<< 8);
        y_full = (acc + (longint'(1) <<< 19)) >>> 20;
        if (y_full > y_hi) begin
            y_full = y_hi;
            hist_clamps++;
        end else if (y_full < -y_hi - 1) begin
            y_full = -y_hi - 1;
            hist_clamps++;
        end
        for (int k = 0; k < TAPS - 1; k++) begin
            y_hist[k] = y_hist[k + 1];
            x_hist[k] = x_hist[k + 1];
        end
        y_hist[TAPS-1] = HW'(y_full);
        x_hist[TAPS-1] = x;
        o_full = (y_full + 128) >>> 8;
        if (o_full > o_hi) begin
            o_full = o_hi;
        end else if (o_full < -o_hi - 1) begin
            o_full = -o_hi - 1;
        end
        return SW'(o_full);
    endfunction

    task automatic queue_sample(input logic signed [SW-1:0] v, input bit burst, input bit drain);
        t_sample_item it;
        it.sample = v;
        it.gap    = burst ? 0 : $urandom_range(0, 10);
        it.drain  = drain;
        pending_samples.push_back(it);
        total_items++;
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            gap_count  <= 0;
            acc_strobe <= 1'b0;
        end else begin
            acc_strobe <= i_in_valid && !o_in_stall;
            if (i_in_valid && !o_in_stall) begin
                acc_sample   <= i_sample_in;
                samples_sent <= samples_sent + 1;
            end
            if (i_in_valid && o_in_stall) begin
                in_stall_cycles <= in_stall_cycles + 1;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (pending_samples.size() == 0) begin
                    i_in_valid <= 1'b0;
                end else if (pending_samples[0].drain &&
                             samples_sent + int'(i_in_valid) != results_seen) begin
                    i_in_valid <= 1'b0;
                end else if (gap_count < pending_samples[0].gap) begin
                    gap_count  <= gap_count + 1;
                    i_in_valid <= 1'b0;
                end else begin
                    i_sample_in <= pending_samples[0].sample;
                    i_in_valid  <= 1'b1;
                    gap_count   <= 0;
                    pending_samples.delete(0);
                end
            end
        end
    end

    // monitor and predictor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            for (int k = 0; k < TAPS; k++) begin
                x_hist[k] = '0;
                y_hist[k] = '0;
            end
        end else begin
            if (acc_strobe) begin
                predicted = advance_filter(acc_sample);
                filt_expect_q.push_back(predicted);
            end
            if (o_out_valid && !i_out_stall) begin
                results_seen <= results_seen + 1;
                if (filt_expect_q.size() == 0) begin
                    err_count++;
                    if (err_count <= 10) begin
                        $display("unexpected result %0d at cycle %0d", o_filtered_out,
                                 cycle_count);
                    end
                end else begin
                    expected = filt_expect_q.pop_front();
                    if (o_filtered_out !== expected) begin
                        err_count++;
                        if (err_count <= 10) begin
                            $display("filtered_out mismatch at cycle %0d: expected %0d, got %0d",
                                     cycle_count, expected, o_filtered_out);
                        end
                    end
                end
                if (rx_burst_left > 0) begin
                    rx_burst_left--;
                    rx_wait = 0;
                end else begin
                    rx_wait = $urandom_range(0, 10);
                    if ($urandom_range(0, 15) == 0) begin
                        rx_burst_left = $urandom_range(20, 60);
                    end
                end
            end
            // long output hold while the sender keeps offering
            if (holds_done < 2 && samples_sent >= 300 + 600 * holds_done) begin
                hold_left = LONG_HOLD;
                holds_done++;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (rx_wait > 0) begin
                rx_wait--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb_iir_lowpass_order5_top failed");
            $finish;
        end
    end

    initial begin
        int                   rand_count;
        int                   kind;
        int                   n;
        int                   half;
        bit                   burst;
        bit                   drain;
        logic signed [SW-1:0] v;

        queue_sample('0, 1'b0, 1'b0);
        queue_sample(S_MAX, 1'b0, 1'b0);
        queue_sample(S_MIN, 1'b0, 1'b0);
        queue_sample(S_MIN, 1'b0, 1'b0);
        queue_sample(S_MAX, 1'b0, 1'b0);
        queue_sample(SW'(1), 1'b0, 1'b0);
        queue_sample(SW'(-1), 1'b0, 1'b0);
        queue_sample(SW'(16'h5555), 1'b0, 1'b0);
        queue_sample(SW'(16'haaaa), 1'b0, 1'b0);
        queue_sample(S_MAX, 1'b1, 1'b0);
        for (int k = 0; k < 5; k++) begin
            queue_sample('0, 1'b1, 1'b0);
        end
        for (int k = 0; k < 3; k++) begin
            queue_sample(S_MIN, 1'b1, 1'b0);
        end
        for (int k = 0; k < 3; k++) begin
            queue_sample(S_MAX, 1'b1, 1'b0);
        end

        // hold the first random sample until the directed ones drain
        rand_count = 0;
        drain      = 1'b1;
        while (rand_count < RAND_ITEMS) begin
            kind  = $urandom_range(0, 4);
            burst = ($urandom_range(0, 3) == 0);
            case (kind)
                0: begin
                    n = $urandom_range(10, 40);
                    for (int k = 0; k < n; k++) begin
                        queue_sample(SW'($urandom), burst, drain && k == 0);
                    end
                end
                1: begin
                    n = $urandom_range(30, 80);
                    v = $urandom_range(0, 1) ? S_MAX : S_MIN;
                    for (int k = 0; k < n; k++) begin
                        queue_sample(v, burst, drain && k == 0);
                    end
                end
                2: begin
                    half = $urandom_range(3, 30);
                    n    = 2 * half * $urandom_range(1, 3);
                    for (int k = 0; k < n; k++) begin
                        queue_sample(((k / half) % 2 == 0) ? S_MAX : S_MIN, burst,
                                     drain && k == 0);
                    end
                end
                3: begin
                    n = $urandom_range(10, 40);
                    for (int k = 0; k < n; k++) begin
                        queue_sample(SW'(int'($urandom_range(0, 128)) - 64), burst,
                                     drain && k == 0);
                    end
                end
                default: begin
                    n = $urandom_range(20, 60);
                    v = SW'($urandom);
                    for (int k = 0; k < n; k++) begin
                        queue_sample(v, burst, drain && k == 0);
                    end
                end
            endcase
            rand_count += n;
            drain = ($urandom_range(0, 9) == 0);
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (samples_sent != total_items || results_seen != samples_sent) begin
            @(posedge i_clk);
        end
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        if (filt_expect_q.size() != 0) begin
            err_count++;
            $display("%0d expected results never arrived", filt_expect_q.size());
        end

        $display("%0d samples filtered, %0d results checked, %0d history clamps,",
                 samples_sent, results_seen, hist_clamps);
        $display("%0d input stall cycles, %0d long output holds, %0d mismatches",
                 in_stall_cycles, holds_done, err_count);
        if (err_count == 0) begin
            $display("tb_iir_lowpass_order5_top passed");
        end else begin
            $display("tb_iir_lowpass_order5_top failed");
        end
        $finish;
    end

endmodule
